### rtl/fmet_pkg.sv
`timescale 1ns / 1ps
package fmet_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 15;
	localparam int CHUNK_W    = 15;
	localparam int LIMIT_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_STEPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 1'b1;

	localparam logic [CHUNK_W-1:0] CHUNK_STEPS_RST = 15'd179;
	localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RST = 8'd17;

	// command codes
	localparam logic [1:0] CMD_CHUNK = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// measurement constants
	localparam logic [15:0] DY_LOW_START = 16'd200;
	localparam logic [7:0]  ERR_SAT      = 8'd255;

	// classified item, front to back
	typedef struct packed {
		logic [1:0]  cmd;
		logic        fwd;
		logic        dy_neg;
		logic        dy_pos;
		logic        half_over;
		logic        full_chunk;
		logic [15:0] step;
		logic [15:0] dy;
		logic [7:0]  shutter;
		logic        ok;
		logic [7:0]  skip;
	} cls_t;

	// one result transaction
	typedef struct packed {
		logic [7:0]  err_count;
		logic        runout;
		logic        sensor_fault;
		logic [7:0]  sample_count;
		logic [15:0] step_sum;
		logic [15:0] dy_sum;
		logic [15:0] error_sum;
		logic [7:0]  error_max;
		logic [15:0] dy_min;
		logic [15:0] dy_max;
		logic [15:0] shutter_sum;
	} res_t;

endpackage

### rtl/filament_motion_error_tracker.sv
`timescale 1ns / 1ps
// Filament motion error tracker: one transaction per command (chunk event, start or stop
// measurement, or no-op) and exactly one result transaction per command, in order,
// carrying the error counter, the runout and sensor fault flags and all measurement
// accumulators as they stand after that command. Throughput is one transaction per
// clock while neither side stalls; an accepted command waits in the command queue and
// its result appears on the result side once it is applied, ready to be popped.
// The front classifies each command into a two-entry command queue, the back applies
// it to the tracker state and parks the result in a two-entry result queue, so up to
// four transactions may be in flight and each side stalls on its own.
// Configuration writes are always ready and must only be issued while nothing is in
// flight.
module filament_motion_error_tracker
	import fmet_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// command side
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            cmd,
	input  logic signed [15:0]    step_count,
	input  logic signed [15:0]    delta_y,
	input  logic [7:0]            shutter,
	input  logic                  sensor_ok,
	input  logic [7:0]            skip_chunks,
	// result side
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            err_count,
	output logic                  runout,
	output logic                  sensor_fault,
	output logic [7:0]            sample_count,
	output logic [15:0]           step_sum,
	output logic [15:0]           dy_sum,
	output logic [15:0]           error_sum,
	output logic [7:0]            error_max,
	output logic [15:0]           dy_min,
	output logic [15:0]           dy_max,
	output logic [15:0]           shutter_sum
);

	// configuration registers
	logic [CHUNK_W-1:0] chunk_steps_q;
	logic [LIMIT_W-1:0] error_limit_q;

	// front to queue to back
	cls_t cls;
	cls_t q_item;
	logic q_valid;
	logic q_take;
	logic push_ok;
	res_t res;

	// transactions accepted but not yet delivered
	logic [2:0] inflight_q;

	assign cfg_ready = 1'b1;
	assign push_ok   = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_steps_q <= CHUNK_STEPS_RST;
			error_limit_q <= ERROR_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHUNK_STEPS: chunk_steps_q <= cfg_data[CHUNK_W-1:0];
				REG_ERROR_LIMIT: error_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// decode and flag each incoming command
	fmet_front u_front (
		.cmd         (cmd),
		.step_count  (step_count),
		.delta_y     (delta_y),
		.shutter     (shutter),
		.sensor_ok   (sensor_ok),
		.skip_chunks (skip_chunks),
		.chunk_steps (chunk_steps_q),
		.cls         (cls)
	);

	// decoupling queue between front and back
	fmet_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push_ok),
		.wr_item  (cls),
		.full     (full),
		.rd_en    (q_take),
		.rd_item  (q_item),
		.rd_valid (q_valid)
	);

	// state update and result queue
	fmet_exec u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (q_item),
		.item_valid  (q_valid),
		.item_take   (q_take),
		.error_limit (error_limit_q),
		.pop         (pop),
		.empty       (empty),
		.res         (res)
	);

	assign err_count    = res.err_count;
	assign runout       = res.runout;
	assign sensor_fault = res.sensor_fault;
	assign sample_count = res.sample_count;
	assign step_sum     = res.step_sum;
	assign dy_sum       = res.dy_sum;
	assign error_sum    = res.error_sum;
	assign error_max    = res.error_max;
	assign dy_min       = res.dy_min;
	assign dy_max       = res.dy_max;
	assign shutter_sum  = res.shutter_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else if (push_ok && !(pop && !empty)) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (!push_ok && pop && !empty) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	// two queues of two entries bound what can be in flight
	assert property (@(posedge clk) disable iff (!arst_n) inflight_q <= 3'd4)
		else $error("more transactions in flight than queue space");

	// a result is only shown for a transaction that was accepted
	assert property (@(posedge clk) disable iff (!arst_n) !empty |-> inflight_q != 3'd0)
		else $error("result shown with nothing in flight");

	// the command queue only fills when both queues hold transactions
	assert property (@(posedge clk) disable iff (!arst_n) full |-> inflight_q >= 3'd2)
		else $error("command queue full with too few transactions in flight");

	// runout on a waiting result agrees with the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && runout) |-> (err_count > error_limit_q))
		else $error("runout flagged at or below the error limit");

endmodule

### rtl/fmet_front.sv
`timescale 1ns / 1ps
module fmet_front
	import fmet_pkg::*;
(
	input  logic [1:0]         cmd,
	input  logic signed [15:0] step_count,
	input  logic signed [15:0] delta_y,
	input  logic [7:0]         shutter,
	input  logic               sensor_ok,
	input  logic [7:0]         skip_chunks,
	input  logic [CHUNK_W-1:0] chunk_steps,
	output cls_t               cls
);

	logic signed [15:0] half_chunk;

	assign half_chunk = $signed({2'b00, chunk_steps[CHUNK_W-1:1]});

	always_comb begin
		cls.cmd        = cmd;
		cls.fwd        = !step_count[15] && (step_count != 16'sd0);
		cls.dy_neg     = delta_y[15];
		cls.dy_pos     = !delta_y[15] && (delta_y != 16'sd0);
		cls.half_over  = step_count > half_chunk;
		// unsigned compare of the step count against the chunk length
		cls.full_chunk = !step_count[15] && (step_count[CHUNK_W-1:0] == chunk_steps);
		cls.step       = step_count;
		cls.dy         = delta_y;
		cls.shutter    = shutter;
		cls.ok         = sensor_ok;
		cls.skip       = skip_chunks;
	end

endmodule

### rtl/fmet_cmdq.sv
`timescale 1ns / 1ps
module fmet_cmdq
	import fmet_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cls_t wr_item,
	output logic full,
	input  logic rd_en,
	output cls_t rd_item,
	output logic rd_valid
);

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q[1];
	assign rd_valid = cnt_q != 2'd0;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### rtl/fmet_exec.sv
`timescale 1ns / 1ps
module fmet_exec
	import fmet_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cls_t               item,
	input  logic               item_valid,
	output logic               item_take,
	input  logic [LIMIT_W-1:0] error_limit,
	input  logic               pop,
	output logic               empty,
	output res_t               res
);

	// tracker state
	logic [7:0]  cnt_q;
	logic        prev_le0_q;
	logic        meas_q;
	logic        watch_q;
	logic [7:0]  skip_q;
	logic [7:0]  samples_q;
	logic [15:0] steps_q;
	logic [15:0] dsum_q;
	logic [15:0] esum_q;
	logic [7:0]  peak_q;
	logic [15:0] low_q;
	logic [15:0] high_q;
	logic [15:0] shut_q;
	logic        fault_q;

	logic [7:0]  cnt_n;
	logic        prev_le0_n;
	logic        meas_n;
	logic        watch_n;
	logic [7:0]  skip_n;
	logic [7:0]  samples_n;
	logic [15:0] steps_n;
	logic [15:0] dsum_n;
	logic [15:0] esum_n;
	logic [7:0]  peak_n;
	logic [15:0] low_n;
	logic [15:0] high_n;
	logic [15:0] shut_n;
	logic        fault_n;

	logic [8:0]  sat_sum;
	logic [7:0]  cnt_mv;
	logic [16:0] low_avg;
	logic [16:0] high_avg;

	// result queue
	res_t       oq_q [2];
	logic       oq_wr_q;
	logic       oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic       oq_pop;
	res_t       res_n;

	assign empty     = oq_cnt_q == 2'd0;
	assign oq_pop    = pop && !empty;
	assign item_take = item_valid && (!oq_cnt_q[1] || oq_pop);
	assign res       = oq_q[oq_rd_q];

	assign low_avg  = {1'b0, low_q} + {1'b0, item.dy};
	assign high_avg = {1'b0, high_q} + {1'b0, item.dy};

	// counter move on a forward chunk, before any skip clear
	always_comb begin
		sat_sum = 9'd0;
		cnt_mv  = cnt_q;
		if (item.dy_neg) begin
			sat_sum = {1'b0, cnt_q} + ((cnt_q != 8'd0) ? 9'd2 : 9'd1);
			cnt_mv  = sat_sum[8] ? ERR_SAT : sat_sum[7:0];
		end else if (item.dy_pos) begin
			cnt_mv = (cnt_q != 8'd0) ? cnt_q - 8'd1 : cnt_q;
		end else if ((prev_le0_q || cnt_q != 8'd0) && item.half_over) begin
			sat_sum = {1'b0, cnt_q} + 9'd1;
			cnt_mv  = sat_sum[8] ? ERR_SAT : sat_sum[7:0];
		end
	end

	always_comb begin
		cnt_n      = cnt_q;
		prev_le0_n = prev_le0_q;
		meas_n     = meas_q;
		watch_n    = watch_q;
		skip_n     = skip_q;
		samples_n  = samples_q;
		steps_n    = steps_q;
		dsum_n     = dsum_q;
		esum_n     = esum_q;
		peak_n     = peak_q;
		low_n      = low_q;
		high_n     = high_q;
		shut_n     = shut_q;
		fault_n    = fault_q;
		unique case (item.cmd)
			CMD_CHUNK: begin
				fault_n    = fault_q || !item.ok;
				prev_le0_n = !item.dy_pos;
				if (item.fwd) begin
					cnt_n = cnt_mv;
					if (meas_q) begin
						if (skip_q != 8'd0) begin
							skip_n = skip_q - 8'd1;
							cnt_n  = 8'd0;
						end else begin
							if (item.full_chunk) begin
								if (item.dy_pos && low_q > item.dy) begin
									low_n = low_avg[16:1];
								end
								if (!item.dy_neg && high_q < item.dy) begin
									high_n = high_avg[16:1];
								end
							end
							samples_n = samples_q + 8'd1;
							steps_n   = steps_q + item.step;
							if (item.dy_pos) begin
								dsum_n = dsum_q + item.dy;
							end
							if (cnt_mv > cnt_q) begin
								esum_n = esum_q + {8'd0, cnt_mv - cnt_q};
							end
							if (peak_q < cnt_mv) begin
								peak_n = cnt_mv;
							end
							shut_n = shut_q + {8'd0, item.shutter};
						end
					end
				end
			end
			CMD_START: begin
				skip_n    = item.skip;
				samples_n = 8'd0;
				steps_n   = 16'd0;
				dsum_n    = 16'd0;
				esum_n    = 16'd0;
				peak_n    = 8'd0;
				low_n     = DY_LOW_START;
				high_n    = 16'd0;
				shut_n    = 16'd0;
				watch_n   = 1'b0;
				meas_n    = 1'b1;
			end
			CMD_STOP: begin
				meas_n  = 1'b0;
				watch_n = 1'b1;
				cnt_n   = 8'd0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_n.err_count    = cnt_n;
		res_n.runout       = watch_n && (cnt_n > error_limit);
		res_n.sensor_fault = fault_n;
		res_n.sample_count = samples_n;
		res_n.step_sum     = steps_n;
		res_n.dy_sum       = dsum_n;
		res_n.error_sum    = esum_n;
		res_n.error_max    = peak_n;
		res_n.dy_min       = low_n;
		res_n.dy_max       = high_n;
		res_n.shutter_sum  = shut_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= 8'd0;
			prev_le0_q <= 1'b1;
			meas_q     <= 1'b0;
			watch_q    <= 1'b1;
			skip_q     <= 8'd0;
			samples_q  <= 8'd0;
			steps_q    <= 16'd0;
			dsum_q     <= 16'd0;
			esum_q     <= 16'd0;
			peak_q     <= 8'd0;
			low_q      <= DY_LOW_START;
			high_q     <= 16'd0;
			shut_q     <= 16'd0;
			fault_q    <= 1'b0;
		end else if (item_take) begin
			cnt_q      <= cnt_n;
			prev_le0_q <= prev_le0_n;
			meas_q     <= meas_n;
			watch_q    <= watch_n;
			skip_q     <= skip_n;
			samples_q  <= samples_n;
			steps_q    <= steps_n;
			dsum_q     <= dsum_n;
			esum_q     <= esum_n;
			peak_q     <= peak_n;
			low_q      <= low_n;
			high_q     <= high_n;
			shut_q     <= shut_n;
			fault_q    <= fault_n;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			oq_q[oq_wr_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (item_take) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			if (item_take && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 2'd1;
			end else if (!item_take && oq_pop) begin
				oq_cnt_q <= oq_cnt_q - 2'd1;
			end
		end
	end

endmodule

### verif/filament_motion_error_tracker_tb.sv
`timescale 1ns / 1ps
module filament_motion_error_tracker_tb;
	import fmet_pkg::*;

	// one command transaction as the sender sees it
	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] step_count;
		logic signed [15:0] delta_y;
		logic [7:0]         shutter;
		logic               sensor_ok;
		logic [7:0]         skip_chunks;
	} command_t;

	// tracks the error counter and measurement, queues the expected reports
	class tracker_scoreboard;
		res_t               expected_reports[$];
		int                 errors;
		logic [CHUNK_W-1:0] chunk_len;
		logic [LIMIT_W-1:0] err_limit;
		logic [7:0]         err_cnt;
		int                 last_dy;
		bit                 in_measure;
		bit                 watching;
		bit                 fault_seen;
		logic [7:0]         skips_pending;
		logic [7:0]         n_samples;
		logic [15:0]        step_acc;
		logic [15:0]        dy_acc;
		logic [15:0]        err_acc;
		logic [7:0]         err_peak;
		logic [15:0]        dy_low;
		logic [15:0]        dy_high;
		logic [15:0]        shutter_acc;

		function new();
			errors = 0;
			chunk_len = CHUNK_STEPS_RST;
			err_limit = ERROR_LIMIT_RST;
			err_cnt = '0;
			last_dy = 0;
			in_measure = 0;
			watching = 1;
			fault_seen = 0;
			skips_pending = '0;
			clear_stats();
		endfunction

		function void clear_stats();
			n_samples = '0;
			step_acc = '0;
			dy_acc = '0;
			err_acc = '0;
			err_peak = '0;
			dy_low = DY_LOW_START;
			dy_high = '0;
			shutter_acc = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_CHUNK_STEPS: chunk_len = val[CHUNK_W-1:0];
				REG_ERROR_LIMIT: err_limit = val[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] bump(logic [7:0] cnt, int amount);
			int sum;
			sum = int'(cnt) + amount;
			return (sum > int'(ERR_SAT)) ? ERR_SAT : 8'(sum);
		endfunction

		function void note_command(command_t c);
			int         st;
			int         dy;
			logic [7:0] prior;
			res_t       r;
			st = $signed(c.step_count);
			dy = $signed(c.delta_y);
			case (c.cmd)
				CMD_CHUNK: begin
					if (!c.sensor_ok)
						fault_seen = 1;
					prior = err_cnt;
					if (st > 0) begin
						if (dy < 0)
							err_cnt = bump(err_cnt, (err_cnt != 0) ? 2 : 1);
						else if (dy > 0) begin
							if (err_cnt != 0)
								err_cnt = err_cnt - 8'd1;
						end else if ((last_dy <= 0 || err_cnt != 0) &&
								st > int'(chunk_len >> 1))
							err_cnt = bump(err_cnt, 1);
						if (in_measure) begin
							if (skips_pending != 0) begin
								skips_pending = skips_pending - 8'd1;
								err_cnt = '0;
							end else begin
								if (st == int'(chunk_len)) begin
									if (dy > 0 && int'(dy_low) > dy)
										dy_low = 16'((int'(dy_low) + dy) / 2);
									if (dy >= 0 && int'(dy_high) < dy)
										dy_high = 16'((int'(dy_high) + dy) / 2);
								end
								n_samples = n_samples + 8'd1;
								step_acc = step_acc + 16'(st);
								if (dy > 0)
									dy_acc = dy_acc + 16'(dy);
								if (err_cnt > prior)
									err_acc = err_acc + 16'(err_cnt - prior);
								if (err_peak < err_cnt)
									err_peak = err_cnt;
								shutter_acc = shutter_acc + 16'(c.shutter);
							end
						end
					end
					last_dy = dy;
				end
				CMD_START: begin
					skips_pending = c.skip_chunks;
					clear_stats();
					watching = 0;
					in_measure = 1;
				end
				CMD_STOP: begin
					in_measure = 0;
					watching = 1;
					err_cnt = '0;
				end
				default: ;
			endcase
			r.err_count = err_cnt;
			r.runout = watching && (err_cnt > err_limit);
			r.sensor_fault = fault_seen;
			r.sample_count = n_samples;
			r.step_sum = step_acc;
			r.dy_sum = dy_acc;
			r.error_sum = err_acc;
			r.error_max = err_peak;
			r.dy_min = dy_low;
			r.dy_max = dy_high;
			r.shutter_sum = shutter_acc;
			expected_reports.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, exp_v, act_v);
			end
		endfunction

		function void check_report(res_t got);
			res_t exp_r;
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual err_count %0d",
					$time, got.err_count);
				return;
			end
			exp_r = expected_reports.pop_front();
			compare_field("err_count", exp_r.err_count, got.err_count);
			compare_field("runout", exp_r.runout, got.runout);
			compare_field("sensor_fault", exp_r.sensor_fault, got.sensor_fault);
			compare_field("sample_count", exp_r.sample_count, got.sample_count);
			compare_field("step_sum", exp_r.step_sum, got.step_sum);
			compare_field("dy_sum", exp_r.dy_sum, got.dy_sum);
			compare_field("error_sum", exp_r.error_sum, got.error_sum);
			compare_field("error_max", exp_r.error_max, got.error_max);
			compare_field("dy_min", exp_r.dy_min, got.dy_min);
			compare_field("dy_max", exp_r.dy_max, got.dy_max);
			compare_field("shutter_sum", exp_r.shutter_sum, got.shutter_sum);
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic [1:0]            cmd = CMD_NOP;
	logic signed [15:0]    step_count = '0;
	logic signed [15:0]    delta_y = '0;
	logic [7:0]            shutter = '0;
	logic                  sensor_ok = 1'b1;
	logic [7:0]            skip_chunks = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [7:0]            err_count;
	logic                  runout;
	logic                  sensor_fault;
	logic [7:0]            sample_count;
	logic [15:0]           step_sum;
	logic [15:0]           dy_sum;
	logic [15:0]           error_sum;
	logic [7:0]            error_max;
	logic [15:0]           dy_min;
	logic [15:0]           dy_max;
	logic [15:0]           shutter_sum;

	tracker_scoreboard board;

	// stimulus knobs, changed between phases
	int chunk_cfg = int'(CHUNK_STEPS_RST);
	int start_pm = 20;
	int stop_pm = 20;
	int neg_pct = 30;
	bit tx_rush = 0;
	bit rx_rush = 0;

	filament_motion_error_tracker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.step_count   (step_count),
		.delta_y      (delta_y),
		.shutter      (shutter),
		.sensor_ok    (sensor_ok),
		.skip_chunks  (skip_chunks),
		.empty        (empty),
		.pop          (pop),
		.err_count    (err_count),
		.runout       (runout),
		.sensor_fault (sensor_fault),
		.sample_count (sample_count),
		.step_sum     (step_sum),
		.dy_sum       (dy_sum),
		.error_sum    (error_sum),
		.error_max    (error_max),
		.dy_min       (dy_min),
		.dy_max       (dy_max),
		.shutter_sum  (shutter_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic command_t mk(logic [1:0] c, int st, int dy, int sh, bit ok, int skip);
		command_t it;
		it.cmd = c;
		it.step_count = 16'(st);
		it.delta_y = 16'(dy);
		it.shutter = 8'(sh);
		it.sensor_ok = ok;
		it.skip_chunks = 8'(skip);
		return it;
	endfunction

	// random command; fields a command ignores still carry random bits
	function automatic command_t draw_command();
		command_t c;
		int       p;
		int       q;
		c.step_count = 16'($urandom);
		c.delta_y = 16'($urandom);
		c.shutter = 8'($urandom);
		c.skip_chunks = 8'($urandom);
		c.sensor_ok = ($urandom_range(0, 199) != 0);
		p = $urandom_range(0, 999);
		if (p < start_pm) begin
			c.cmd = CMD_START;
			q = $urandom_range(0, 99);
			// mostly short skips so the measurement gets going
			if (q < 70)
				c.skip_chunks = 8'($urandom_range(0, 3));
			else if (q < 90)
				c.skip_chunks = 8'($urandom_range(0, 20));
		end else if (p < start_pm + stop_pm)
			c.cmd = CMD_STOP;
		else if (p < start_pm + stop_pm + 5)
			c.cmd = CMD_NOP;
		else begin
			c.cmd = CMD_CHUNK;
			// step count: full chunk, partial, around the half threshold, wild, backward
			q = $urandom_range(0, 99);
			if (q < 55)
				c.step_count = 16'(chunk_cfg);
			else if (q < 75)
				c.step_count = 16'($urandom_range(0, chunk_cfg));
			else if (q < 85)
				c.step_count = 16'((chunk_cfg >> 1) + $urandom_range(0, 1));
			else if (q >= 93)
				c.step_count = 16'(-int'($urandom_range(0, 300)));
			// sensor delta: backward, none or forward, with a few wild values
			if ($urandom_range(0, 99) >= 5) begin
				q = $urandom_range(0, 99);
				if (q < neg_pct)
					c.delta_y = 16'(-int'($urandom_range(1, 60)));
				else if (q < neg_pct + (100 - neg_pct) / 3)
					c.delta_y = '0;
				else if ($urandom_range(0, 9) != 0)
					c.delta_y = 16'($urandom_range(1, 400));
				else
					c.delta_y = 16'($urandom_range(1, 32767));
			end
			if ($urandom_range(0, 2) == 0)
				c.shutter = 8'd255;
		end
		return c;
	endfunction

	// one command transaction, after a random gap
	task automatic send_item(command_t it);
		int gap;
		gap = tx_rush ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= it.cmd;
		step_count <= it.step_count;
		delta_y <= it.delta_y;
		shutter <= it.shutter;
		sensor_ok <= it.sensor_ok;
		skip_chunks <= it.skip_chunks;
		do @(posedge clk); while (full);
		board.note_command(it);
	endtask

	// hold the sender until every expected report is back
	task automatic drain_results();
		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// valid is left high between back-to-back writes
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
	endtask

	task automatic set_config(int chunk, int limit);
		drain_results();
		write_reg(REG_CHUNK_STEPS, CFG_DATA_W'(chunk));
		write_reg(REG_ERROR_LIMIT, CFG_DATA_W'(limit));
		cfg_valid <= 1'b0;
		chunk_cfg = chunk;
	endtask

	task automatic run_random(int n, int starts, int stops, int neg, bit hold_mid);
		start_pm = starts;
		stop_pm = stops;
		neg_pct = neg;
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2)
				drain_results();
			send_item(draw_command());
		end
	endtask

	// result side: random stalls, every popped transaction goes to the scoreboard
	initial begin
		int   gap;
		res_t got;
		wait (arst_n);
		forever begin
			gap = rx_rush ? 0 : $urandom_range(0, 9);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.err_count = err_count;
			got.runout = runout;
			got.sensor_fault = sensor_fault;
			got.sample_count = sample_count;
			got.step_sum = step_sum;
			got.dy_sum = dy_sum;
			got.error_sum = error_sum;
			got.error_max = error_max;
			got.dy_min = dy_min;
			got.dy_max = dy_max;
			got.shutter_sum = shutter_sum;
			board.check_report(got);
		end
	end

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset register values
		send_item(mk(CMD_NOP, 5, 5, 7, 1, 9));
		send_item(mk(CMD_CHUNK, 179, 0, 10, 1, 0));       // no motion from a still start
		send_item(mk(CMD_CHUNK, 90, 0, 10, 1, 0));        // just above half a chunk
		send_item(mk(CMD_CHUNK, 89, 0, 10, 1, 0));        // exactly half, no count
		send_item(mk(CMD_CHUNK, 179, 5, 10, 1, 0));       // forward lowers the count
		send_item(mk(CMD_CHUNK, 179, 0, 10, 1, 0));       // still after forward, count nonzero
		send_item(mk(CMD_CHUNK, -32768, -32768, 0, 1, 0)); // retraction is ignored
		send_item(mk(CMD_CHUNK, 0, -1, 0, 1, 0));          // no steps
		send_item(mk(CMD_CHUNK, 32767, -1, 0, 1, 0));      // backward adds two
		send_item(mk(CMD_CHUNK, 1, 32767, 0, 1, 0));
		send_item(mk(CMD_START, 0, 0, 0, 1, 2));
		send_item(mk(CMD_CHUNK, 179, -5, 40, 1, 0));      // skipped chunks clear the count
		send_item(mk(CMD_CHUNK, 179, 10, 40, 1, 0));
		send_item(mk(CMD_CHUNK, 179, 150, 40, 1, 0));     // full chunk moves min and max
		send_item(mk(CMD_CHUNK, 179, 0, 40, 1, 0));
		send_item(mk(CMD_CHUNK, 100, -3, 40, 1, 0));      // partial chunk
		send_item(mk(CMD_CHUNK, 179, 32767, 255, 1, 0));
		send_item(mk(CMD_START, 0, 0, 0, 1, 0));          // restart while measuring
		send_item(mk(CMD_CHUNK, 179, -32768, 0, 1, 0));
		send_item(mk(CMD_STOP, 0, 0, 0, 1, 0));
		send_item(mk(CMD_STOP, 0, 0, 0, 1, 0));           // stop when not measuring
		send_item(mk(CMD_START, 0, 0, 0, 1, 255));
		send_item(mk(CMD_STOP, 0, 0, 0, 1, 0));
		send_item(mk(CMD_CHUNK, 179, 0, 128, 0, 0));      // failed readout
		send_item(mk(CMD_NOP, 0, 0, 0, 1, 0));

		// default setting, mixed traffic
		set_config(179, 17);
		run_random(250, 30, 30, 30, 0);

		// one-step chunk and zero limit, sender at full rate
		set_config(1, 0);
		tx_rush = 1;
		run_random(200, 20, 20, 40, 0);
		tx_rush = 0;

		// mostly backward motion while watching, counter runs into saturation
		set_config(32767, 200);
		rx_rush = 1;
		send_item(mk(CMD_STOP, 0, 0, 0, 1, 0));
		run_random(300, 2, 4, 90, 0);
		rx_rush = 0;

		// one long measurement so the accumulators wrap
		set_config(32767, 255);
		send_item(mk(CMD_START, 0, 0, 0, 1, 0));
		run_random(550, 0, 0, 30, 0);

		// zero chunk length, both sides at full rate
		set_config(0, $urandom_range(0, 255));
		tx_rush = 1;
		rx_rush = 1;
		run_random(150, 20, 20, 40, 0);
		tx_rush = 0;
		rx_rush = 0;

		// random setting with a full drain in the middle
		set_config($urandom_range(1, 400), $urandom_range(0, 40));
		run_random(300, 20, 20, 35, 1);

		// back to the reset values
		set_config(int'(CHUNK_STEPS_RST), int'(ERROR_LIMIT_RST));
		tx_rush = 1;
		run_random(100, 20, 20, 30, 0);

		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
